// ===== src/low_memory_page_bitmap_allocator_unit_assert.svh =====
// Assertion macros for the page allocator datapath.
`ifndef LOW_MEMORY_PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define LOW_MEMORY_PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define LMPBA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LMPBA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/lmpba_pkg.sv =====
// Types and constants for the low memory page bitmap allocator.
package lmpba_pkg;

   localparam int PAGE_SHIFT   = 12;
   localparam int PAGE_BYTES   = 1 << PAGE_SHIFT;
   localparam int REGION_PAGES = 256;
   localparam int WORD_PAGES   = 32;
   localparam int MAP_WORDS    = (REGION_PAGES + WORD_PAGES - 1) / WORD_PAGES;
   localparam int PAGE_W       = $clog2(REGION_PAGES);
   localparam int WORD_IDX_W   = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W    = $clog2(WORD_PAGES);
   localparam int ADDR_W       = 32;
   localparam int COUNT_W      = ADDR_W + 1 - PAGE_SHIFT;

   localparam logic [ADDR_W:0] REGION_END = (ADDR_W+1)'(REGION_PAGES) << PAGE_SHIFT;

   typedef enum logic [1:0] {
      MODE_RESERVE = 2'd0,
      MODE_ALLOC   = 2'd1,
      MODE_RELEASE = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_RANGE,
      ST_SWEEP,
      ST_SCAN,
      ST_DROP,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic ready;
      logic latch_req;
      logic clamp_len;
      logic calc_range;
      logic sweep_word;
      logic scan_word;
      logic drop_page;
      logic step_word;
      logic load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] req_mode;
      logic       scan_hit;
      logic       word_last;
      logic       out_busy;
   } dp_status_type;

endpackage

// ===== src/lmpba_ctrl.sv =====
// Sequencer for the page allocator: decodes the mode and steps the map datapath.
module lmpba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  lmpba_pkg::dp_status_type status,
   output lmpba_pkg::dp_cmd_type    cmd
);
   import lmpba_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) begin
               case (status.req_mode)
                  MODE_RESERVE: state_in = ST_CLAMP;
                  MODE_ALLOC:   state_in = ST_SCAN;
                  MODE_RELEASE: state_in = ST_DROP;
                  default:      state_in = ST_REPLY;
               endcase
            end
         end
         ST_CLAMP: state_in = ST_RANGE;
         ST_RANGE: state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (status.word_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_SCAN: begin
            if (status.scan_hit || status.word_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_DROP: state_in = ST_REPLY;
         ST_REPLY: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.ready     = 1'b1;
            cmd.latch_req = status.req_valid;
         end
         ST_CLAMP: cmd.clamp_len  = 1'b1;
         ST_RANGE: cmd.calc_range = 1'b1;
         ST_SWEEP: begin
            cmd.sweep_word = 1'b1;
            cmd.step_word  = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_word = 1'b1;
            cmd.step_word = 1'b1;
         end
         ST_DROP:  cmd.drop_page = 1'b1;
         ST_REPLY: cmd.load_rsp  = !status.out_busy;
         default:  cmd = '0;
      endcase
   end

endmodule

// ===== src/lmpba_dp.sv =====
// Datapath: request registers, page bitmap, range mask, free-page search, result word.
module lmpba_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  lmpba_pkg::dp_cmd_type    cmd,
   output lmpba_pkg::dp_status_type status,
   input  logic [63:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   input  logic                    req_tvalid,
   output logic [7:0]              rsp_tdata,
   output logic [0:0]              rsp_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready
);
   import lmpba_pkg::*;

   logic [ADDR_W-1:0]        loc_ff;
   logic [ADDR_W-1:0]        span_ff;
   logic [ADDR_W-1:0]        len_ff;
   logic [PAGE_W:0]          lo_ff;
   logic [PAGE_W:0]          hi_ff;
   logic [WORD_IDX_W-1:0]    word_ff;
   logic [WORD_PAGES-1:0]    map_ff [MAP_WORDS];
   logic [WORD_PAGES-1:0]    map_in [MAP_WORDS];
   logic [PAGE_W-1:0]        page_res_ff;
   logic                     found_res_ff;
   logic [7:0]               rsp_page_ff;
   logic                     rsp_found_ff;
   logic                     rsp_valid_ff;

   logic [ADDR_W:0]          range_sum;
   logic [ADDR_W-1:0]        len_in;
   logic                     in_region;
   logic [COUNT_W-1:0]       page_count;
   logic [PAGE_W+1:0]        hi_sum;
   logic [PAGE_W:0]          lo_in;
   logic [PAGE_W:0]          hi_in;
   logic [WORD_PAGES-1:0]    cur_word;
   logic [WORD_PAGES-1:0]    sweep_mask;
   logic [PAGE_W:0]          bit_page;
   logic                     scan_hit;
   logic [BIT_IDX_W-1:0]     free_bit;
   logic                     word_last;
   logic                     drop_ok;

   // Clamp the length at the region end
   assign range_sum = {1'b0, loc_ff} + {1'b0, span_ff};
   assign len_in    = (range_sum >= REGION_END) ? ADDR_W'(REGION_END - {1'b0, loc_ff})
                                                : span_ff;

   assign in_region  = (loc_ff >> (PAGE_SHIFT + PAGE_W)) == '0;
   assign page_count = COUNT_W'(({1'b0, len_ff} + (ADDR_W+1)'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
   assign hi_sum     = (PAGE_W+2)'(loc_ff[PAGE_SHIFT +: PAGE_W]) + (PAGE_W+2)'(page_count[PAGE_W:0]);

   always_comb begin
      lo_in = '0;
      hi_in = '0;
      if (in_region) begin
         lo_in = {1'b0, loc_ff[PAGE_SHIFT +: PAGE_W]};
         if (page_count >= COUNT_W'(REGION_PAGES) || hi_sum >= (PAGE_W+2)'(REGION_PAGES)) begin
            hi_in = (PAGE_W+1)'(REGION_PAGES);
         end else begin
            hi_in = hi_sum[PAGE_W:0];
         end
      end
   end

   assign cur_word  = map_ff[word_ff];
   assign word_last = word_ff == WORD_IDX_W'(MAP_WORDS - 1);

   always_comb begin
      sweep_mask = '0;
      bit_page   = '0;
      for (int b = 0; b < WORD_PAGES; b++) begin
         bit_page      = {1'b0, word_ff, BIT_IDX_W'(b)};
         sweep_mask[b] = (bit_page >= lo_ff) && (bit_page < hi_ff);
      end
   end

   // Lowest clear bit of the current word
   always_comb begin
      free_bit = '0;
      for (int b = WORD_PAGES - 1; b >= 0; b--) begin
         if (!cur_word[b]) begin
            free_bit = BIT_IDX_W'(b);
         end
      end
   end
   assign scan_hit = ~&cur_word;

   // Page 0 is never released once marked used
   assign drop_ok = ((loc_ff >> PAGE_W) == '0) && (loc_ff[PAGE_W-1:0] != '0);

   always_comb begin
      map_in = map_ff;
      if (cmd.sweep_word) begin
         map_in[word_ff] = cur_word | sweep_mask;
      end else if (cmd.scan_word && scan_hit) begin
         map_in[word_ff][free_bit] = 1'b1;
      end else if (cmd.drop_page && drop_ok) begin
         map_in[loc_ff[PAGE_W-1 -: WORD_IDX_W]][loc_ff[BIT_IDX_W-1:0]] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < MAP_WORDS; w++) begin
            map_ff[w] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff <= map_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         loc_ff       <= req_tdata[31:0];
         span_ff      <= req_tdata[63:32];
         word_ff      <= '0;
         page_res_ff  <= '0;
         found_res_ff <= 1'b1;
      end else if (cmd.step_word) begin
         word_ff <= word_ff + WORD_IDX_W'(1);
      end
      if (cmd.clamp_len) begin
         len_ff <= len_in;
      end
      if (cmd.calc_range) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
      if (cmd.scan_word) begin
         if (scan_hit) begin
            page_res_ff <= {word_ff, free_bit};
         end else if (word_last) begin
            found_res_ff <= 1'b0;
         end
      end
      if (cmd.load_rsp) begin
         rsp_page_ff  <= 8'(page_res_ff);
         rsp_found_ff <= found_res_ff;
      end
   end

   assign status.req_valid = req_tvalid;
   assign status.req_mode  = req_tuser;
   assign status.scan_hit  = scan_hit;
   assign status.word_last = word_last;
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_tdata  = rsp_page_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tvalid = rsp_valid_ff;

`include "low_memory_page_bitmap_allocator_unit_assert.svh"

   `LMPBA_ASSERT(a_page0_kept, (cmd.drop_page && loc_ff == '0) |=> $stable(map_ff[0][0]), "page 0 released")
   `LMPBA_ASSERT(a_load_free, cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready), "result overwritten before taken")
   `LMPBA_ASSERT(a_alloc_marks, (cmd.scan_word && scan_hit) |=> (found_res_ff && map_ff[page_res_ff[PAGE_W-1 -: WORD_IDX_W]][page_res_ff[BIT_IDX_W-1:0]]), "allocated page not marked used")
   `LMPBA_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

// ===== src/low_memory_page_bitmap_allocator_unit.sv =====
// From accept to result: reserve steps through clamp, range and a sweep of every map word,
// allocate scans map words until a free page or the last word, release drops the page, unused mode replies.
// A new request is accepted only once the current one has left the reply step; a result not yet taken
// holds the reply step.
// Reset (synchronous, active high) clears the whole bitmap at once, so every page is free.
// The result register holds a finished word while the next request is accepted.
module low_memory_page_bitmap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] location, [63:32] span_bytes
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] page_number
   output logic [0:0]  rsp_tuser    // [0] found
);
   import lmpba_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   lmpba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   lmpba_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   assign req_tready = cmd.ready;

endmodule
